[rtl/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tfn_pkg;
  localparam int FIELD_W = 32;
  localparam int OUT_W   = 16;
  localparam int LANES   = 3;
endpackage
`default_nettype wire

[rtl/tfn_cross.sv]
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, cross product terms, difference and magnitude (4 stages).
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_cross #(
  parameter int CW = 32
) (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  logic [tfn_pkg::FIELD_W-1:0] a [tfn_pkg::LANES],
  input  logic [tfn_pkg::FIELD_W-1:0] b [tfn_pkg::LANES],
  input  logic [tfn_pkg::FIELD_W-1:0] c [tfn_pkg::LANES],
  output logic [2*CW+1:0]             mag [tfn_pkg::LANES],
  output logic [tfn_pkg::LANES-1:0]   neg
);
  import tfn_pkg::*;

  localparam int EW = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int DW = 2 * CW + 3;
  localparam int MW = 2 * CW + 2;

  logic signed [EW-1:0] ae [LANES];
  logic signed [EW-1:0] be [LANES];
  logic signed [EW-1:0] ce [LANES];
  logic signed [EW-1:0] e1 [LANES];
  logic signed [EW-1:0] e2 [LANES];
  logic signed [PW-1:0] pr [2*LANES];
  logic signed [DW-1:0] d [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ae[i] = EW'($signed(a[i][CW-1:0]));
      be[i] = EW'($signed(b[i][CW-1:0]));
      ce[i] = EW'($signed(c[i][CW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        e1[i] <= be[i] - ae[i];
        e2[i] <= ce[i] - ae[i];
      end
    end
    if (en[1]) begin
      pr[0] <= PW'(e1[1]) * PW'(e2[2]);
      pr[1] <= PW'(e1[2]) * PW'(e2[1]);
      pr[2] <= PW'(e1[2]) * PW'(e2[0]);
      pr[3] <= PW'(e1[0]) * PW'(e2[2]);
      pr[4] <= PW'(e1[0]) * PW'(e2[1]);
      pr[5] <= PW'(e1[1]) * PW'(e2[0]);
    end
    if (en[2]) begin
      for (int i = 0; i < LANES; i++) begin
        d[i] <= DW'(pr[2*i]) - DW'(pr[2*i+1]);
      end
    end
    if (en[3]) begin
      for (int i = 0; i < LANES; i++) begin
        neg[i] <= d[i][DW-1];
        mag[i] <= d[i][DW-1] ? MW'(-d[i]) : MW'(d[i]);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/tfn_square.sv]
// ----------------------------------------------------------------------------
// tfn_square
// Squares of the normal terms, squared length and root search setup (4 stages).
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_square #(
  parameter int CW = 32,
  parameter int F  = 14
) (
  input  logic                           clk,
  input  logic [3:0]                     en,
  input  logic [2*CW+1:0]                mag [tfn_pkg::LANES],
  input  logic [tfn_pkg::LANES-1:0]      neg_in,
  output logic signed [4*CW+2*F+10:0]    r [tfn_pkg::LANES],
  output logic signed [4*CW+2*F+10:0]    p [tfn_pkg::LANES],
  output logic [4*CW+5:0]                s,
  output logic [tfn_pkg::LANES-1:0]      neg,
  output logic                           deg
);
  import tfn_pkg::*;

  localparam int MW = 2 * CW + 2;
  localparam int LW = CW + 1;
  localparam int HW = MW - LW;
  localparam int QW = 2 * MW;
  localparam int SW = 4 * CW + 6;
  localparam int RW = 4 * CW + 2 * F + 11;

  logic [2*LW-1:0]  hh [LANES];
  logic [2*LW-1:0]  hl [LANES];
  logic [2*LW-1:0]  ll [LANES];
  logic [QW-1:0]    sq [LANES];
  logic [QW-1:0]    t [LANES];
  logic [SW-1:0]    s7;
  logic [LANES-1:0] neg5, neg6, neg7;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        hh[i] <= (2*LW)'(mag[i][MW-1:LW]) * (2*LW)'(mag[i][MW-1:LW]);
        hl[i] <= (2*LW)'(mag[i][MW-1:LW]) * (2*LW)'(mag[i][LW-1:0]);
        ll[i] <= (2*LW)'(mag[i][LW-1:0]) * (2*LW)'(mag[i][LW-1:0]);
      end
      neg5 <= neg_in;
    end
    if (en[1]) begin
      for (int i = 0; i < LANES; i++) begin
        sq[i] <= (QW'(hh[i]) << (2*LW)) + (QW'(hl[i]) << (LW+1)) + QW'(ll[i]);
      end
      neg6 <= neg5;
    end
    if (en[2]) begin
      s7 <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      for (int i = 0; i < LANES; i++) begin
        t[i] <= sq[i];
      end
      neg7 <= neg6;
    end
    if (en[3]) begin
      for (int i = 0; i < LANES; i++) begin
        r[i] <= $signed(RW'(t[i]) << (2*F+2)) - $signed(RW'(s7));
        p[i] <= -$signed(RW'(s7));
      end
      s   <= s7;
      deg <= (s7 == '0);
      neg <= neg7;
    end
  end

  logic unused_hw;
  assign unused_hw = (HW == LW);
endmodule
`default_nettype wire

[rtl/tfn_root_step.sv]
// ----------------------------------------------------------------------------
// tfn_root_step
// One bit of the rounded unit component search, all three lanes.
// ----------------------------------------------------------------------------
`default_nettype none
module tfn_root_step #(
  parameter int CW = 32,
  parameter int F  = 14,
  parameter int K  = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [4*CW+2*F+10:0]    r_in [tfn_pkg::LANES],
  input  logic signed [4*CW+2*F+10:0]    p_in [tfn_pkg::LANES],
  input  logic [F:0]                     q_in [tfn_pkg::LANES],
  input  logic [4*CW+5:0]                s_in,
  input  logic [tfn_pkg::LANES-1:0]      neg_in,
  input  logic                           deg_in,
  output logic signed [4*CW+2*F+10:0]    r [tfn_pkg::LANES],
  output logic signed [4*CW+2*F+10:0]    p [tfn_pkg::LANES],
  output logic [F:0]                     q [tfn_pkg::LANES],
  output logic [4*CW+5:0]                s,
  output logic [tfn_pkg::LANES-1:0]      neg,
  output logic                           deg
);
  import tfn_pkg::*;

  localparam int RW = 4 * CW + 2 * F + 11;

  logic signed [RW-1:0] d [LANES];
  logic signed [RW-1:0] sp;
  logic [LANES-1:0]     take;

  always_comb begin
    sp = $signed(RW'(s_in) << (K+1));
    for (int i = 0; i < LANES; i++) begin
      d[i]    = (p_in[i] <<< (K+2)) + $signed(RW'(s_in) << (2*K+2));
      take[i] = (d[i] <= r_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        r[i] <= take[i] ? r_in[i] - d[i] : r_in[i];
        p[i] <= take[i] ? p_in[i] + sp : p_in[i];
        q[i] <= take[i] ? (q_in[i] | ((F+1)'(1) << K)) : q_in[i];
      end
      s   <= s_in;
      neg <= neg_in;
      deg <= deg_in;
    end
  end
endmodule
`default_nettype wire

[rtl/triangle_face_normal.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: exact cross product, rounded Q1.F result.
// ----------------------------------------------------------------------------
//  channel  signals                           direction
//  in       in_valid/in_ready, ax..cz         into block
//  out      out_valid/out_ready, nx,ny,nz,    out of block
//           degenerate
//
//  One triangle per cycle unless the output stalls; the one-bit-per-stage root
//  search follows 8 stages of cross product and squares.
//  Every stage has its own valid bit; a stage loads when empty or when the
//  next one moves, so a stalled output fills bubbles and drops nothing.
//  rst clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_face_normal #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tfn_pkg::FIELD_W-1:0] ax,
  input  logic signed [tfn_pkg::FIELD_W-1:0] ay,
  input  logic signed [tfn_pkg::FIELD_W-1:0] az,
  input  logic signed [tfn_pkg::FIELD_W-1:0] bx,
  input  logic signed [tfn_pkg::FIELD_W-1:0] by,
  input  logic signed [tfn_pkg::FIELD_W-1:0] bz,
  input  logic signed [tfn_pkg::FIELD_W-1:0] cx,
  input  logic signed [tfn_pkg::FIELD_W-1:0] cy,
  input  logic signed [tfn_pkg::FIELD_W-1:0] cz,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tfn_pkg::OUT_W-1:0]  nx,
  output logic signed [tfn_pkg::OUT_W-1:0]  ny,
  output logic signed [tfn_pkg::OUT_W-1:0]  nz,
  output logic                              degenerate
);
  import tfn_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = NORMAL_FRAC_BITS;
  localparam int MW = 2 * CW + 2;
  localparam int SW = 4 * CW + 6;
  localparam int RW = 4 * CW + 2 * F + 11;
  localparam int N  = F + 10;

  logic [N-1:0] v;
  logic [N:0]   rdy;

  logic [FIELD_W-1:0] a [LANES];
  logic [FIELD_W-1:0] b [LANES];
  logic [FIELD_W-1:0] c [LANES];

  logic [MW-1:0]    mag [LANES];
  logic [LANES-1:0] neg4;

  logic signed [RW-1:0] r_st [F+2][LANES];
  logic signed [RW-1:0] p_st [F+2][LANES];
  logic [F:0]           q_st [F+2][LANES];
  logic [SW-1:0]        s_st [F+2];
  logic [LANES-1:0]     n_st [F+2];
  logic                 d_st [F+2];

  logic signed [31:0] qv [LANES];
  logic signed [31:0] res [LANES];

  always_comb begin
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    c[0] = cx; c[1] = cy; c[2] = cz;
  end

  always_comb begin
    rdy[N] = out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  tfn_cross #(.CW(CW)) u_cross (
    .clk (clk),
    .en  (rdy[3:0]),
    .a   (a),
    .b   (b),
    .c   (c),
    .mag (mag),
    .neg (neg4)
  );

  tfn_square #(.CW(CW), .F(F)) u_square (
    .clk    (clk),
    .en     (rdy[7:4]),
    .mag    (mag),
    .neg_in (neg4),
    .r      (r_st[0]),
    .p      (p_st[0]),
    .s      (s_st[0]),
    .neg    (n_st[0]),
    .deg    (d_st[0])
  );

  for (genvar i = 0; i < LANES; i++) begin : g_q0
    assign q_st[0][i] = '0;
  end

  for (genvar j = 0; j <= F; j++) begin : g_step
    tfn_root_step #(.CW(CW), .F(F), .K(F - j)) u_step (
      .clk    (clk),
      .en     (rdy[8+j]),
      .r_in   (r_st[j]),
      .p_in   (p_st[j]),
      .q_in   (q_st[j]),
      .s_in   (s_st[j]),
      .neg_in (n_st[j]),
      .deg_in (d_st[j]),
      .r      (r_st[j+1]),
      .p      (p_st[j+1]),
      .q      (q_st[j+1]),
      .s      (s_st[j+1]),
      .neg    (n_st[j+1]),
      .deg    (d_st[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      qv[i]  = $signed(32'(q_st[F+1][i]));
      res[i] = n_st[F+1][i] ? -qv[i] : qv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N-1]) begin
      nx         <= d_st[F+1] ? '0 : res[0][OUT_W-1:0];
      ny         <= d_st[F+1] ? '0 : res[1][OUT_W-1:0];
      nz         <= d_st[F+1] ? '0 : res[2][OUT_W-1:0];
      degenerate <= d_st[F+1];
    end
  end

  logic unused_tail;
  assign unused_tail = ^{r_st[F+1][0], r_st[F+1][1], r_st[F+1][2],
                         p_st[F+1][0], p_st[F+1][1], p_st[F+1][2], s_st[F+1]};
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_face_normal. A directed table, then random
// triangles, with random gaps on both channels. An exact wide-integer model
// predicts each normal the table lacks; the result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import tfn_pkg::*;

  localparam int FRAC      = 14;
  localparam int N_RANDOM  = 1800;
  localparam int MAX_CYC   = 400000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic signed [FIELD_W-1:0] v[9];
  } tri_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             deg;
  } normal_t;

  typedef struct {
    tri_t    t;
    bit      typed;
    normal_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [FIELD_W-1:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
  logic signed [FIELD_W-1:0] cx = 0, cy = 0, cz = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [OUT_W-1:0] nx, ny, nz;
  logic degenerate;

  normal_t normals_due[$];
  row_t    dir_rows[$];
  int      errors = 0;
  int      cycles = 0;
  bit      long_hold = 0;
  bit      no_idle = 0;

  triangle_face_normal #(.COORD_WIDTH(32), .NORMAL_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz),
    .out_valid(out_valid), .out_ready(out_ready),
    .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic normal_t face_normal(tri_t t);
    logic signed [33:0]  e1[3];
    logic signed [33:0]  e2[3];
    logic signed [69:0]  n[3];
    logic [191:0]        mag[3];
    logic [191:0]        sumsq, lhs, rhs;
    logic                neg[3];
    logic [63:0]         odd;
    logic [15:0]         q[3];
    longint              lo, hi, mid;
    normal_t             r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = {{2{t.v[3+i][31]}}, t.v[3+i]} - {{2{t.v[i][31]}}, t.v[i]};
      e2[i] = {{2{t.v[6+i][31]}}, t.v[6+i]} - {{2{t.v[i][31]}}, t.v[i]};
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i][69];
      mag[i] = '0;
      mag[i][69:0] = neg[i] ? -n[i] : n[i];
      sumsq += mag[i] * mag[i];
    end
    if (sumsq == 0) begin
      r = '{x: '0, y: '0, z: '0, deg: 1'b1};
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      rhs = (mag[i] * mag[i]) << (2 * FRAC + 2);
      lo = 0;
      hi = longint'(1) << FRAC;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 64'(2 * mid - 1);
        lhs = sumsq * {128'd0, odd * odd};
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      q[i] = neg[i] ? -16'(lo) : 16'(lo);
    end
    r = '{x: q[0], y: q[1], z: q[2], deg: 1'b0};
    return r;
  endfunction

  function automatic tri_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                              int c0, int c1, int c2);
    tri_t t;
    t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return t;
  endfunction

  task automatic add_row(tri_t t, bit typed, logic [15:0] x, logic [15:0] y,
                         logic [15:0] z, logic d);
    row_t r;
    r.t = t;
    r.typed = typed;
    r.want = '{x: x, y: y, z: z, deg: d};
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic send(tri_t t, bit typed, normal_t want);
    int gap;
    gap = 0;
    if (!no_idle) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {ax, ay, az} <= {t.v[0], t.v[1], t.v[2]};
    {bx, by, bz} <= {t.v[3], t.v[4], t.v[5]};
    {cx, cy, cz} <= {t.v[6], t.v[7], t.v[8]};
    do @(posedge clk); while (!in_ready);
    normals_due.insert(normals_due.size(), typed ? want : face_normal(t));
  endtask

  function automatic tri_t rand_tri();
    tri_t t;
    int   kind, k;
    logic signed [31:0] d[3];
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) t.v[i] = $urandom;
    if (kind < 30) begin
      for (int i = 0; i < 9; i++) t.v[i] = $urandom_range(0, 2000) - 1000;
    end else if (kind < 45) begin
      k = $urandom_range(0, 6) - 3;
      for (int i = 0; i < 3; i++) begin
        t.v[i] = $urandom_range(0, 1 << 20) - (1 << 19);
        d[i] = $urandom_range(0, 1 << 16) - (1 << 15);
        t.v[3+i] = t.v[i] + d[i];
        t.v[6+i] = t.v[i] + k * d[i];
      end
    end else if (kind < 55) begin
      for (int i = 0; i < 9; i++)
        case ($urandom_range(0, 3))
          0: t.v[i] = 32'sh7FFFFFFF;
          1: t.v[i] = 32'sh80000000;
          2: t.v[i] = 0;
          default: ;
        endcase
    end
    return t;
  endfunction

  // receiver side
  initial begin
    int stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 0;
      end else if (no_idle) begin
        out_ready <= 1;
      end else begin
        if (stall == 0) begin
          r = $urandom_range(0, 99);
          if (r < 3) stall = $urandom_range(10, 40);
          else if (r < 20) stall = $urandom_range(1, 3);
        end
        if (stall > 0) begin
          stall--;
          out_ready <= 0;
        end else begin
          out_ready <= 1;
        end
      end
    end
  end

  // result check
  always @(posedge clk) begin
    normal_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{x: nx, y: ny, z: nz, deg: degenerate};
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected transaction, got %h", $time, got);
        errors++;
      end else begin
        want = normals_due.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: nx expected %h actual %h", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: ny expected %h actual %h", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: nz expected %h actual %h", $time, want.z, got.z);
          errors++;
        end
        if (got.deg !== want.deg) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.deg, got.deg);
          errors++;
        end
      end
    end
  end

  initial begin
    localparam int ONE = 65536;
    localparam int MX  = 32'h7FFFFFFF;
    localparam int MN  = 32'h80000000;
    normal_t none;
    none = '0;

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 1);
    add_row(mk(MX, MX, MX, MX, MX, MX, MX, MX, MX), 1, 0, 0, 0, 1);
    add_row(mk(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE), 1, 0, 0, 0, 1);
    add_row(mk(MN, MN, MN, 0, 0, 0, MX, MX, MX), 1, 0, 0, 0, 1);
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1, 0, 0, 16'sd16384, 0);
    add_row(mk(0, 0, 0, 0, ONE, 0, ONE, 0, 0), 1, 0, 0, -16'sd16384, 0);
    add_row(mk(0, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, 16'sd16384, 0, 0, 0);
    add_row(mk(0, 0, 0, 0, 0, ONE, ONE, 0, 0), 1, 0, 16'sd16384, 0, 0);
    add_row(mk(MN, MN, MN, MX, MN, MN, MN, MX, MN), 1, 0, 0, 16'sd16384, 0);
    add_row(mk(MX, MX, MX, MN, MX, MX, MX, MN, MX), 1, 0, 0, 16'sd16384, 0);
    add_row(mk(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, 0, 0, 16'sd16384, 0);
    add_row(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0, 0, 0, 0, 0);
    add_row(mk(MX, 0, 0, 0, MX, 0, 0, 0, MX), 0, 0, 0, 0, 0);
    add_row(mk(MN, 0, 0, 0, MN, 0, 0, 0, MN), 0, 0, 0, 0, 0);
    add_row(mk(MN, MX, MN, MX, MN, MX, MX, MX, MN), 0, 0, 0, 0, 0);
    add_row(mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
               32'h55555555, 32'hFFFFFFFF, 0, 32'h12345678), 0, 0, 0, 0, 0);
    add_row(mk(0, 0, 0, 3, 1, 0, 1, 2, 5), 0, 0, 0, 0, 0);
    add_row(mk(-1, -1, -1, 1, -1, -1, -1, 1, -1), 0, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 0;

    foreach (dir_rows[i]) send(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 300 && i < 450);
      if (i == 600) long_hold = 1;
      if (i == 1200) begin
        in_valid <= 0;
        @(posedge clk);
        while (normals_due.size() != 0) @(posedge clk);
      end
      send(rand_tri(), 0, none);
    end
    in_valid <= 0;

    while (normals_due.size() != 0) @(posedge clk);
    repeat (FRAC + 30) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

[triangle_face_normal.f]
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_square.sv
rtl/tfn_root_step.sv
rtl/triangle_face_normal.sv
tb/tb.sv
